// ----- rtl/mea_pkg.sv -----
// ----------------------------------------------------------------------------
// mea_pkg: shared types and constants of the monomial exponent ALU
// Lane layout, mode/order/error codes and the records passed between stages.
// ----------------------------------------------------------------------------
`default_nettype none

package mea_pkg;

  localparam int NUM_VARS  = 4;    // active variables, 1..4
  localparam int EXP_BITS  = 16;   // exponent bits per lane, 8..16
  localparam int LANE_BITS = 16;   // lane pitch in the packed word
  localparam int MAX_LANES = 4;
  localparam int DATA_BITS = LANE_BITS * MAX_LANES;
  localparam int DEG_BITS  = 18;
  localparam int MODE_BITS = 3;

  typedef logic [EXP_BITS-1:0] lane_t;
  typedef lane_t [NUM_VARS-1:0] lanes_t;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_MUL  = 3'd0,
    MODE_DIV  = 3'd1,
    MODE_GCD  = 3'd2,
    MODE_LCM  = 3'd3,
    MODE_TEST = 3'd4,
    MODE_CMP  = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    ORD_LESS    = 2'd0,
    ORD_EQUAL   = 2'd1,
    ORD_GREATER = 2'd2
  } order_t;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_OVF  = 2'd1,
    ERR_DIV  = 2'd2
  } err_t;

  // Stage 1: per-lane arithmetic and compares
  typedef struct packed {
    logic [MODE_BITS-1:0] mode;
    lanes_t               a;
    lanes_t               b;
    lanes_t               sum;
    lanes_t               diff;
    logic [NUM_VARS-1:0]  carry;
    logic [NUM_VARS-1:0]  b_gt;
    logic [NUM_VARS-1:0]  ne;
  } s1_t;

  // Stage 2: selected lanes and flags
  typedef struct packed {
    lanes_t res;
    logic   divides;
    order_t order;
    err_t   err;
  } s2_t;

  // Stage 3: finished result
  typedef struct packed {
    logic [DATA_BITS-1:0] result_exps;
    logic [DEG_BITS-1:0]  total_degree;
    logic                 is_one;
    logic                 b_divides_a;
    order_t               order;
    err_t                 error;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/mea_lane_stage.sv -----
// ----------------------------------------------------------------------------
// mea_lane_stage: first pipeline stage
// Unpacks both operands and registers lane sums, differences and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module mea_lane_stage (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             vld_in,
  input  wire logic [mea_pkg::MODE_BITS-1:0]    mode,
  input  wire logic [mea_pkg::DATA_BITS-1:0]    a_exps,
  input  wire logic [mea_pkg::DATA_BITS-1:0]    b_exps,
  output logic                                  s1_vld_r,
  output mea_pkg::s1_t                          s1_r
);

  mea_pkg::s1_t s1_nxt;
  logic [mea_pkg::EXP_BITS:0] wide_sum [mea_pkg::NUM_VARS];

  always_comb begin
    s1_nxt      = '0;
    s1_nxt.mode = mode;
    for (int i = 0; i < mea_pkg::NUM_VARS; i++) begin
      // keep only the exponent bits of each lane
      s1_nxt.a[i]     = a_exps[mea_pkg::LANE_BITS*i +: mea_pkg::EXP_BITS];
      s1_nxt.b[i]     = b_exps[mea_pkg::LANE_BITS*i +: mea_pkg::EXP_BITS];
      wide_sum[i]     = {1'b0, s1_nxt.a[i]} + {1'b0, s1_nxt.b[i]};
      s1_nxt.sum[i]   = wide_sum[i][mea_pkg::EXP_BITS-1:0];
      s1_nxt.carry[i] = wide_sum[i][mea_pkg::EXP_BITS];
      s1_nxt.diff[i]  = s1_nxt.a[i] - s1_nxt.b[i];
      s1_nxt.b_gt[i]  = s1_nxt.b[i] > s1_nxt.a[i];
      s1_nxt.ne[i]    = s1_nxt.b[i] != s1_nxt.a[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/mea_sel_stage.sv -----
// ----------------------------------------------------------------------------
// mea_sel_stage: second pipeline stage
// Resolves divisibility and lex order, picks each result lane by mode.
// ----------------------------------------------------------------------------
`default_nettype none

module mea_sel_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          s1_vld,
  input  wire mea_pkg::s1_t  s1,
  output logic               s2_vld_r,
  output mea_pkg::s2_t       s2_r
);

  mea_pkg::s2_t  s2_nxt;
  mea_pkg::mode_t mode;

  always_comb begin
    mode           = mea_pkg::mode_t'(s1.mode);
    s2_nxt         = '0;
    s2_nxt.divides = ~|s1.b_gt;
    s2_nxt.order   = mea_pkg::ORD_EQUAL;
    // scan from the top lane down so the lowest differing lane wins
    for (int i = mea_pkg::NUM_VARS - 1; i >= 0; i--) begin
      if (s1.ne[i]) begin
        s2_nxt.order = s1.b_gt[i] ? mea_pkg::ORD_LESS : mea_pkg::ORD_GREATER;
      end
    end
    for (int i = 0; i < mea_pkg::NUM_VARS; i++) begin
      case (mode)
        mea_pkg::MODE_MUL: s2_nxt.res[i] = s1.sum[i];
        mea_pkg::MODE_DIV: s2_nxt.res[i] = s2_nxt.divides ? s1.diff[i] : '0;
        mea_pkg::MODE_GCD: s2_nxt.res[i] = s1.b_gt[i] ? s1.a[i] : s1.b[i];
        mea_pkg::MODE_LCM: s2_nxt.res[i] = s1.b_gt[i] ? s1.b[i] : s1.a[i];
        default:           s2_nxt.res[i] = s1.a[i];
      endcase
    end
    s2_nxt.err = mea_pkg::ERR_NONE;
    if (mode == mea_pkg::MODE_MUL && |s1.carry) begin
      s2_nxt.err = mea_pkg::ERR_OVF;
    end
    if (mode == mea_pkg::MODE_DIV && !s2_nxt.divides) begin
      s2_nxt.err = mea_pkg::ERR_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    s2_r <= s2_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/mea_deg_stage.sv -----
// ----------------------------------------------------------------------------
// mea_deg_stage: third pipeline stage
// Sums the result lanes into the total degree and packs the output word.
// ----------------------------------------------------------------------------
`default_nettype none

module mea_deg_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          s2_vld,
  input  wire mea_pkg::s2_t  s2,
  output logic               res_vld_r,
  output mea_pkg::res_t      res_r
);

  mea_pkg::res_t res_nxt;

  always_comb begin
    res_nxt = '0;
    for (int i = 0; i < mea_pkg::NUM_VARS; i++) begin
      res_nxt.result_exps[mea_pkg::LANE_BITS*i +: mea_pkg::EXP_BITS] = s2.res[i];
      res_nxt.total_degree = res_nxt.total_degree +
        mea_pkg::DEG_BITS'(s2.res[i]);
    end
    res_nxt.is_one      = ~|s2.res;
    res_nxt.b_divides_a = s2.divides;
    res_nxt.order       = s2.order;
    res_nxt.error       = s2.err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else begin
      res_vld_r <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/monomial_exponent_alu_core.sv -----
// ----------------------------------------------------------------------------
// monomial_exponent_alu_core: monomial exponent vector ALU
// Multiply, divide, gcd and lcm of packed exponent vectors (other modes pass A through), with degree,
// divisibility and lexicographic order of each operand pair.
//
//   channel  ports                               handshake
//   -------  ----------------------------------  ------------------------
//   request  in_mode, in_a_exps, in_b_exps       start && !busy
//   result   out_result_exps .. out_error        out_valid, one cycle
//
// One request per cycle; busy is always low. Each result is registered once in
// each of the pipeline stages for lane arithmetic, mode selection and degree
// summation. Synchronous reset clears the valid bits only. The receiver cannot
// stall, so nothing is ever held back.
// ----------------------------------------------------------------------------
`default_nettype none

module monomial_exponent_alu_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [mea_pkg::MODE_BITS-1:0]     in_mode,
  input  wire logic [mea_pkg::DATA_BITS-1:0]     in_a_exps,
  input  wire logic [mea_pkg::DATA_BITS-1:0]     in_b_exps,
  output logic                                   out_valid,
  output logic [mea_pkg::DATA_BITS-1:0]          out_result_exps,
  output logic [mea_pkg::DEG_BITS-1:0]           out_total_degree,
  output logic                                   out_is_one,
  output logic                                   out_b_divides_a,
  output logic [1:0]                             out_order,
  output logic [1:0]                             out_error
);

  logic          s1_vld;
  mea_pkg::s1_t  s1;
  logic          s2_vld;
  mea_pkg::s2_t  s2;
  mea_pkg::res_t res;

  assign busy = 1'b0;

  mea_lane_stage u_lane (
    .clk      (clk),
    .rst_n    (rst_n),
    .vld_in   (start),
    .mode     (in_mode),
    .a_exps   (in_a_exps),
    .b_exps   (in_b_exps),
    .s1_vld_r (s1_vld),
    .s1_r     (s1)
  );

  mea_sel_stage u_sel (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_vld   (s1_vld),
    .s1       (s1),
    .s2_vld_r (s2_vld),
    .s2_r     (s2)
  );

  mea_deg_stage u_deg (
    .clk       (clk),
    .rst_n     (rst_n),
    .s2_vld    (s2_vld),
    .s2        (s2),
    .res_vld_r (out_valid),
    .res_r     (res)
  );

  assign out_result_exps  = res.result_exps;
  assign out_total_degree = res.total_degree;
  assign out_is_one       = res.is_one;
  assign out_b_divides_a  = res.b_divides_a;
  assign out_order        = res.order;
  assign out_error        = res.error;

  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 3))
    else $error("result without a request three cycles earlier");

  a_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error == mea_pkg::ERR_DIV) |->
      (out_is_one && out_total_degree == '0 && !out_b_divides_a))
    else $error("inexact divide did not return the unit monomial");

  a_eq_div: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_order == mea_pkg::ORD_EQUAL) |-> out_b_divides_a)
    else $error("equal operands reported as not dividing");

  a_one_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_one) |->
      (out_result_exps == '0 && out_total_degree == '0))
    else $error("is_one set on a nonzero result");

endmodule

`default_nettype wire

// ----- bench/monomial_exponent_alu_core_tb.sv -----
// ----------------------------------------------------------------------------
// monomial_exponent_alu_core_tb: self-checking bench for the monomial ALU
// Requests with directed corner operands, then random monomial pairs shaped
// to hit exact and inexact division, overflow and ties in the lexicographic
// order. Every result is predicted in the bench and checked field by field.
// ----------------------------------------------------------------------------

module monomial_exponent_alu_core_tb;
  import mea_pkg::*;

  localparam logic [MODE_BITS-1:0] MODE_SPARE6 = 3'd6;
  localparam logic [MODE_BITS-1:0] MODE_SPARE7 = 3'd7;
  localparam logic [DATA_BITS-1:0] ALL_ONES    = {DATA_BITS{1'b1}};
  localparam int RANDOM_REQS = 1630;
  localparam int PHASE_LEN   = 204;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PRINT_LIMIT = 40;

  typedef struct {
    logic [MODE_BITS-1:0] mode;
    logic [DATA_BITS-1:0] a;
    logic [DATA_BITS-1:0] b;
    int                   idle_pct;
  } alu_request_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [MODE_BITS-1:0]  in_mode = '0;
  logic [DATA_BITS-1:0]  in_a_exps = '0;
  logic [DATA_BITS-1:0]  in_b_exps = '0;
  logic                  out_valid;
  logic [DATA_BITS-1:0]  out_result_exps;
  logic [DEG_BITS-1:0]   out_total_degree;
  logic                  out_is_one;
  logic                  out_b_divides_a;
  logic [1:0]            out_order;
  logic [1:0]            out_error;

  alu_request_t op_requests[$];
  res_t         awaited_results[$];
  int           mismatch_count = 0;
  int           cycle_count = 0;

  monomial_exponent_alu_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_a_exps        (in_a_exps),
    .in_b_exps        (in_b_exps),
    .out_valid        (out_valid),
    .out_result_exps  (out_result_exps),
    .out_total_degree (out_total_degree),
    .out_is_one       (out_is_one),
    .out_b_divides_a  (out_b_divides_a),
    .out_order        (out_order),
    .out_error        (out_error)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Lane-wise monomial operation with the divisibility and order flags
  function automatic res_t monomial_op(logic [MODE_BITS-1:0] mode,
                                       logic [DATA_BITS-1:0] a,
                                       logic [DATA_BITS-1:0] b);
    int unsigned          mask;
    int unsigned          x;
    int unsigned          y;
    int unsigned          r;
    int unsigned          deg;
    logic                 divides;
    logic                 ovf;
    order_t               ord;
    logic [DATA_BITS-1:0] res;
    res_t                 e;
    mask    = (1 << EXP_BITS) - 1;
    deg     = 0;
    divides = 1'b1;
    ovf     = 1'b0;
    ord     = ORD_EQUAL;
    res     = '0;
    for (int i = 0; i < NUM_VARS; i++) begin
      x = a[LANE_BITS*i +: LANE_BITS] & mask;
      y = b[LANE_BITS*i +: LANE_BITS] & mask;
      if (y > x) divides = 1'b0;
      // first differing variable decides the order
      if (ord == ORD_EQUAL && x != y) ord = (x < y) ? ORD_LESS : ORD_GREATER;
    end
    for (int i = 0; i < NUM_VARS; i++) begin
      x = a[LANE_BITS*i +: LANE_BITS] & mask;
      y = b[LANE_BITS*i +: LANE_BITS] & mask;
      case (mode)
        MODE_MUL: begin
          r = x + y;
          if (r > mask) ovf = 1'b1;
          r = r & mask;
        end
        MODE_DIV: r = divides ? x - y : 0;
        MODE_GCD: r = (x < y) ? x : y;
        MODE_LCM: r = (x > y) ? x : y;
        default:  r = x;
      endcase
      res = res | (DATA_BITS'(r) << (LANE_BITS * i));
      deg = deg + r;
    end
    e.result_exps  = res;
    e.total_degree = DEG_BITS'(deg);
    e.is_one       = (res == '0);
    e.b_divides_a  = divides;
    e.order        = ord;
    if (mode == MODE_MUL && ovf)
      e.error = ERR_OVF;
    else if (mode == MODE_DIV && !divides)
      e.error = ERR_DIV;
    else
      e.error = ERR_NONE;
    return e;
  endfunction

  function automatic logic [LANE_BITS-1:0] rand_lane();
    case ($urandom_range(0, 3))
      0:       return LANE_BITS'($urandom);
      1:       return LANE_BITS'($urandom_range(0, 3));
      2:       return {LANE_BITS{1'b1}} - LANE_BITS'($urandom_range(0, 15));
      default: return LANE_BITS'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [DATA_BITS-1:0] rand_monomial();
    logic [DATA_BITS-1:0] m;
    for (int i = 0; i < MAX_LANES; i++) m[LANE_BITS*i +: LANE_BITS] = rand_lane();
    return m;
  endfunction

  task automatic add_request(logic [MODE_BITS-1:0] mode, logic [DATA_BITS-1:0] a,
                             logic [DATA_BITS-1:0] b, int idle_pct);
    alu_request_t r;
    r.mode     = mode;
    r.a        = a;
    r.b        = b;
    r.idle_pct = idle_pct;
    op_requests.insert(op_requests.size(), r);
  endtask

  task automatic flag_mismatch(string field, logic [DATA_BITS-1:0] got,
                               logic [DATA_BITS-1:0] want);
    if (mismatch_count < PRINT_LIMIT)
      $display("mismatch on %s at cycle %0d: got %h, want %h",
               field, cycle_count, got, want);
    mismatch_count++;
  endtask

  // Driver: queue a prediction for each accepted request, then load the next one or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy)
        awaited_results.insert(awaited_results.size(),
                               monomial_op(in_mode, in_a_exps, in_b_exps));
      if (start && busy) begin
        // hold the request until taken
      end else if (op_requests.size() != 0 &&
                   $urandom_range(0, 99) >= op_requests[0].idle_pct) begin
        start     <= 1'b1;
        in_mode   <= op_requests[0].mode;
        in_a_exps <= op_requests[0].a;
        in_b_exps <= op_requests[0].b;
        void'(op_requests.pop_front());
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: each strobed result retires the oldest prediction
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid) begin
      if (awaited_results.size() == 0) begin
        flag_mismatch("unrequested result", out_result_exps, '0);
      end else begin
        want = awaited_results.pop_front();
        if (out_result_exps !== want.result_exps)
          flag_mismatch("result_exps", out_result_exps, want.result_exps);
        if (out_total_degree !== want.total_degree)
          flag_mismatch("total_degree", DATA_BITS'(out_total_degree),
                        DATA_BITS'(want.total_degree));
        if (out_is_one !== want.is_one)
          flag_mismatch("is_one", DATA_BITS'(out_is_one), DATA_BITS'(want.is_one));
        if (out_b_divides_a !== want.b_divides_a)
          flag_mismatch("b_divides_a", DATA_BITS'(out_b_divides_a),
                        DATA_BITS'(want.b_divides_a));
        if (out_order !== want.order)
          flag_mismatch("order", DATA_BITS'(out_order), DATA_BITS'(want.order));
        if (out_error !== want.error)
          flag_mismatch("error", DATA_BITS'(out_error), DATA_BITS'(want.error));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("monomial_exponent_alu_core verification failed");
      $finish;
    end
  end

  initial begin
    int                   phase_pct[4];
    logic [DATA_BITS-1:0] a;
    logic [DATA_BITS-1:0] b;
    logic [MODE_BITS-1:0] mode;
    int                   k;
    phase_pct = '{0, 67, 0, 28};

    add_request(MODE_MUL, '0, '0, 0);
    add_request(MODE_MUL, ALL_ONES, ALL_ONES, 0);
    add_request(MODE_MUL, 64'h0001_0002_0003_0004, 64'h0010_0020_0030_0040, 0);
    add_request(MODE_MUL, 64'h7FFF_0000_0000_8000, 64'h8001_0000_0000_7FFF, 0);
    add_request(MODE_MUL, '0, ALL_ONES, 0);
    add_request(MODE_DIV, 64'h0005_0004_0003_0002, 64'h0001_0004_0000_0001, 0);
    add_request(MODE_DIV, 64'h1234_0000_FFFF_0007, 64'h1234_0000_FFFF_0007, 0);
    add_request(MODE_DIV, 64'h0005_0004_0003_0002, 64'h0001_0005_0000_0001, 0);
    add_request(MODE_DIV, '0, ALL_ONES, 0);
    add_request(MODE_DIV, ALL_ONES, '0, 0);
    add_request(MODE_GCD, 64'h0009_0001_0007_0003, 64'h0002_0005_0007_0008, 0);
    add_request(MODE_LCM, 64'h0009_0001_0007_0003, 64'h0002_0005_0007_0008, 0);
    add_request(MODE_GCD, ALL_ONES, '0, 0);
    add_request(MODE_LCM, ALL_ONES, '0, 0);
    add_request(MODE_TEST, ALL_ONES, '0, 0);
    add_request(MODE_TEST, '0, ALL_ONES, 0);
    add_request(MODE_CMP, 64'h0000_0000_0000_0001, 64'h0000_0000_0000_0002, 0);
    add_request(MODE_CMP, ALL_ONES, ALL_ONES, 0);
    add_request(MODE_CMP, 64'h0005_0000_0000_0000, '0, 0);
    add_request(MODE_SPARE6, 64'hFFFF_0000_8001_0001, 64'h0001_0002_0003_0004, 0);
    add_request(MODE_SPARE7, 64'h0001_0002_0003_0004, 64'hFFFF_0000_8001_0001, 0);

    for (int n = 0; n < RANDOM_REQS; n++) begin
      mode = ($urandom_range(0, 9) == 0) ? MODE_BITS'($urandom_range(6, 7))
                                         : MODE_BITS'($urandom_range(0, 5));
      a = rand_monomial();
      case ($urandom_range(0, 4))
        0: b = rand_monomial();
        1: begin
          // B divides A lane by lane
          for (int i = 0; i < MAX_LANES; i++)
            b[LANE_BITS*i +: LANE_BITS] =
              LANE_BITS'($urandom_range(0, a[LANE_BITS*i +: LANE_BITS]));
        end
        2: begin
          // equal prefix, order decided at a random lane
          b = a;
          k = $urandom_range(0, MAX_LANES - 1);
          b[LANE_BITS*k +: LANE_BITS] = rand_lane();
        end
        3: b = a;
        default: b = {$urandom, $urandom};
      endcase
      add_request(mode, a, b, phase_pct[(n / PHASE_LEN) % 4]);
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (op_requests.size() != 0 || start || awaited_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatch_count == 0 && awaited_results.size() == 0)
      $display("monomial_exponent_alu_core verification clean");
    else
      $display("monomial_exponent_alu_core verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/mea_pkg.sv
rtl/mea_lane_stage.sv
rtl/mea_sel_stage.sv
rtl/mea_deg_stage.sv
rtl/monomial_exponent_alu_core.sv
bench/monomial_exponent_alu_core_tb.sv
